// File: design/b2da_pkg.sv
// Shared constants, types and state codes for the binary to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package b2da_pkg;

  localparam int VALUE_BITS = 64;
  localparam int NUM_DIGITS = 20;
  localparam int CHAR_BITS  = 6;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = CHAR_BITS'(48);
  localparam logic [3:0]           BCD_FIVE  = 4'd5;
  localparam logic [3:0]           BCD_THREE = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift_bin;
    logic shift_dig;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: design/b2da_cell.sv
// One BCD digit cell: add-3 correction and binary shift, or digit shift toward the top.
`timescale 1ns / 1ps
`default_nettype none
module b2da_cell
  import b2da_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      carry_in,
  input  wire logic[3:0] digit_in,
  output logic           carry_out,
  output logic [3:0]     digit
);

  logic [3:0] adj;
  logic [3:0] digit_next;

  always_comb begin
    adj = (digit >= BCD_FIVE) ? 4'(digit + BCD_THREE) : digit;
    carry_out = adj[3];
    priority if (ctl.clear) begin
      digit_next = 4'd0;
    end else if (ctl.shift_bin) begin
      digit_next = {adj[2:0], carry_in};
    end else if (ctl.shift_dig) begin
      digit_next = digit_in;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule
`default_nettype wire

// File: design/b2da_ctrl.sv
// Sequencer: loads the value, runs the shift cycles, then walks digits out.
`timescale 1ns / 1ps
`default_nettype none
module b2da_ctrl
  import b2da_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [3:0]            top_digit,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic                       last,
  output logic                       bit_in,
  output cell_ctl_t                  ctl,
  output state_t                     state,
  output logic                       started
);

  state_t                 state_next;
  logic [VALUE_BITS-1:0]  value_sr;
  logic [VALUE_BITS-1:0]  value_sr_next;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [BIT_CNT_W-1:0]   bit_cnt_next;
  logic [DIG_CNT_W-1:0]   remaining;
  logic [DIG_CNT_W-1:0]   remaining_next;
  logic                   started_next;
  logic                   emit_en;

  assign bit_in = value_sr[VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
    value_sr  <= value_sr_next;
    bit_cnt   <= bit_cnt_next;
    remaining <= remaining_next;
  end

  always_comb begin
    state_next     = state;
    started_next   = started;
    value_sr_next  = value_sr;
    bit_cnt_next   = bit_cnt;
    remaining_next = remaining;
    ctl            = '0;
    in_stall       = 1'b1;
    emit_en        = started || (top_digit != 4'd0) || (remaining == DIG_CNT_W'(1));
    out_valid      = 1'b0;
    last           = (remaining == DIG_CNT_W'(1));
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.clear     = 1'b1;
          value_sr_next = value;
          bit_cnt_next  = BIT_CNT_W'(VALUE_BITS - 1);
          state_next    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctl.shift_bin = 1'b1;
        value_sr_next = {value_sr[VALUE_BITS-2:0], 1'b0};
        bit_cnt_next  = bit_cnt - BIT_CNT_W'(1);
        if (bit_cnt == '0) begin
          remaining_next = DIG_CNT_W'(NUM_DIGITS);
          started_next   = 1'b0;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = emit_en;
        if (!emit_en) begin
          // drop a leading zero
          ctl.shift_dig  = 1'b1;
          remaining_next = remaining - DIG_CNT_W'(1);
        end else if (!out_stall) begin
          ctl.shift_dig  = 1'b1;
          remaining_next = remaining - DIG_CNT_W'(1);
          started_next   = 1'b1;
          if (last) begin
            started_next = 1'b0;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/binary_to_decimal_ascii_top.sv
// Top level: converts an unsigned binary value into a run of ASCII decimal digits.
//
// Input channel: in_valid / in_stall with value. One transaction carries the
// number; only the low VALUE_BITS bits are used. in_stall is high whenever a
// conversion is in progress, so one value is handled at a time.
// Output channel: out_valid / out_stall with digit_char and last. One
// transaction per decimal digit, most significant first, no leading zeros;
// zero gives a single '0'. last marks the least significant digit.
// Conversion: the VALUE_BITS bits of the value shift into a row of 20 BCD
// digit cells, then the digits leave the top cell one per cycle while the
// receiver does not stall, as the row shifts upward. Leading zeros are
// dropped at one per cycle. A stall holds the top digit and the whole row;
// digit_char and last stay stable until taken. Reset returns the sequencer
// to idle and discards any run in progress.
`timescale 1ns / 1ps
`default_nettype none
module binary_to_decimal_ascii_top
  import b2da_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [63:0]          value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CHAR_BITS-1:0]      digit_char,
  output logic                      last
);

  cell_ctl_t  ctl;
  state_t     state;
  logic       started;
  logic       bit_in;
  logic [3:0] digits [NUM_DIGITS];
  logic       carries [NUM_DIGITS];

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value[VALUE_BITS-1:0]),
    .top_digit (digits[NUM_DIGITS-1]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .last      (last),
    .bit_in    (bit_in),
    .ctl       (ctl),
    .state     (state),
    .started   (started)
  );

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      b2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (bit_in),
        .digit_in  (4'd0),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end else begin : g_up
      b2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (carries[i-1]),
        .digit_in  (digits[i-1]),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end
  end

  assign digit_char = CHAR_ZERO + CHAR_BITS'(digits[NUM_DIGITS-1]);

`ifndef SYNTHESIS
  a_valid_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT)
    else $error("output valid outside digit phase");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !started && !last) |-> digit_char != CHAR_ZERO)
    else $error("leading zero emitted");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (!out_valid && state == ST_IDLE))
    else $error("run continues after last digit");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_CONVERT && in_stall))
    else $error("accepted value did not start conversion");
`endif

endmodule
`default_nettype wire

// File: test/binary_to_decimal_ascii_top_tb.sv
// Self-checking testbench for the binary to decimal ASCII converter: directed table, random values.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_top_tb;
  import b2da_pkg::*;

  localparam int DIR_N      = 20;
  localparam int RAND_N     = 180;
  localparam int IDLE_PCT   = 26;
  localparam int HOLD_AT    = DIR_N + 20;
  localparam int HOLD_LEN   = 400;
  localparam int CALM_FIRST = DIR_N + 100;
  localparam int CALM_LAST  = DIR_N + 140;
  localparam int DRAIN_CYC  = 1 + VALUE_BITS + NUM_DIGITS + 10;
  localparam int QUIET_MAX  = 4000;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
  } digit_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [63:0]          value     = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last;

  digit_t pending_digits[$];
  digit_t want_digit;
  int     fails     = 0;
  int     n_sent    = 0;
  logic   calm      = 1'b0;
  int     quiet     = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;

  logic [63:0] dir_value [DIR_N] = '{
    64'd0,
    64'd1,
    64'd9,
    64'd10,
    64'd99,
    64'd100,
    64'd1000,
    64'd12345,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'd10000000000000000000,
    64'd9999999999999999999,
    64'd4294967295,
    64'd5678956789,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'h0123_4567_89AB_CDEF,
    64'h0000_0100_0000_0000,
    64'd4294967296
  };

  string dir_text [DIR_N] = '{
    "0",
    "1",
    "9",
    "10",
    "99",
    "100",
    "1000",
    "12345",
    "18446744073709551615",
    "9223372036854775808",
    "9223372036854775807",
    "10000000000000000000",
    "9999999999999999999",
    "4294967295",
    "5678956789",
    "",
    "",
    "",
    "",
    ""
  };

  binary_to_decimal_ascii_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void push_decimal_digits(input logic [63:0] v);
    logic [64:0] mask;
    logic [63:0] rest;
    logic [3:0]  dig [NUM_DIGITS];
    int          n;
    int          i;
    digit_t      d;
    mask = (65'd1 << VALUE_BITS) - 65'd1;
    rest = v & mask[63:0];
    n = 0;
    do begin
      dig[n] = 4'(rest % 64'd10);
      rest = rest / 64'd10;
      n++;
    end while (rest != 64'd0);
    for (i = n - 1; i >= 0; i--) begin
      d.digit_char = CHAR_ZERO + CHAR_BITS'(dig[i]);
      d.last = (i == 0);
      pending_digits.push_back(d);
    end
  endfunction

  task automatic send_value(input logic [63:0] v, input string txt, input int idx);
    digit_t d;
    int     i;
    while (!(idx >= CALM_FIRST && idx < CALM_LAST) && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent <= idx + 1;
    calm <= (idx + 1 >= CALM_FIRST) && (idx + 1 < CALM_LAST);
    if (txt.len() == 0) begin
      push_decimal_digits(v);
    end else begin
      for (i = 0; i < txt.len(); i++) begin
        d.digit_char = CHAR_BITS'(txt[i]);
        d.last = (i == txt.len() - 1);
        pending_digits.push_back(d);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected transaction: digit_char %0d last %0d", digit_char, last);
        fails++;
      end else begin
        want_digit = pending_digits.pop_front();
        if (digit_char !== want_digit.digit_char) begin
          $error("digit_char expected %0d actual %0d", want_digit.digit_char, digit_char);
          fails++;
        end
        if (last !== want_digit.last) begin
          $error("last expected %0d actual %0d", want_digit.last, last);
          fails++;
        end
      end
    end
    // hold off the receiver once so the converter backs up into its input
    if (!hold_done && n_sent == HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_MAX) begin
      $display("binary_to_decimal_ascii_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    int          len;
    int          k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < DIR_N; k++) begin
      send_value(dir_value[k], dir_text[k], k);
    end
    for (k = 0; k < RAND_N; k++) begin
      v = {$urandom, $urandom};
      // spread digit counts: mostly random bit lengths, some full width
      if ($urandom_range(7) != 0) begin
        len = $urandom_range(64, 0);
        if (len < 64) begin
          v = v & ((64'd1 << len) - 64'd1);
        end
      end
      send_value(v, "", DIR_N + k);
    end
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_digits.size() != 0) begin
      $error("digit_char expected %0d more transactions, actual none",
             pending_digits.size());
    end
    if (fails == 0 && pending_digits.size() == 0) begin
      $display("binary_to_decimal_ascii_top regression: pass");
    end else begin
      $display("binary_to_decimal_ascii_top regression: fail");
    end
    $finish;
  end

endmodule
